[hdl/proximity_label_clusterer_top_assert.svh]
// Assertion macros for the proximity label clusterer
`ifndef PROXIMITY_LABEL_CLUSTERER_TOP_ASSERT_SVH
`define PROXIMITY_LABEL_CLUSTERER_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PLC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define PLC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hdl/plc_pkg.sv]
// ----------------------------------------------------------------------------
// plc_pkg
// Shared constants and controller/datapath command and status types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package plc_pkg;
  localparam int MAX_CLUSTERS_DEF = 64;
  localparam int LABEL_SLOTS_DEF  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_DIST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_OFS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM     = 3'd4;
  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request
    logic rd;        // issue read of scan index
    logic chk;       // compare registered read data
    logic wr_new;    // append new cluster
    logic wr_hit;    // update matched cluster
    logic emit;      // drive flush result from read data
    logic emit_empty;
    logic clr;       // clear cluster total
    logic idx_clr;   // scan index back to 0
    logic idx_inc;
  } plc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;       // comparison matched
    logic at_end;    // scan index reached cluster total
    logic empty;
    logic full;
    logic last_idx;  // scan index is total-1
  } plc_sts_t;
endpackage

[hdl/plc_ram.sv]
// ----------------------------------------------------------------------------
// plc_ram
// Generic single-port-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module plc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[hdl/plc_ctrl.sv]
// ----------------------------------------------------------------------------
// plc_ctrl
// Sequencer for add scan and flush walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module plc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              req_type,
  input  plc_pkg::plc_sts_t sts,
  output plc_pkg::plc_cmd_t cmd,
  output logic              busy
);
  import plc_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_CHK = 3'd2,
                         S_FRD = 3'd3, S_FOUT = 3'd4, S_UPD = 3'd5;
  logic [2:0] state_r, state_nxt;
  logic is_flush_r, is_flush_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      is_flush_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      is_flush_r <= is_flush_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    is_flush_nxt = is_flush_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          cmd.idx_clr = 1'b1;
          is_flush_nxt = req_type;
          state_nxt = (req_type == REQ_FLUSH) ? S_FRD : S_RD;
        end
      end
      S_RD: begin
        if (sts.at_end) begin
          if (!sts.full) cmd.wr_new = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        if (sts.hit) begin
          state_nxt = S_UPD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_UPD: begin
        cmd.wr_hit = 1'b1;
        state_nxt = S_IDLE;
      end
      S_FRD: begin
        if (sts.empty) begin
          cmd.emit_empty = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd = 1'b1;
          state_nxt = S_FOUT;
        end
      end
      S_FOUT: begin
        cmd.emit = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.last_idx) begin
          cmd.clr = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_FRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

[hdl/plc_dp.sv]
// ----------------------------------------------------------------------------
// plc_dp
// Cluster tables, match compare and flush result formatting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module plc_dp #(
  parameter int MAX_CLUSTERS = plc_pkg::MAX_CLUSTERS_DEF,
  parameter int LABEL_SLOTS  = plc_pkg::LABEL_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  plc_pkg::plc_cmd_t            cmd,
  output plc_pkg::plc_sts_t            sts,
  input  logic signed [15:0]           pos_x,
  input  logic signed [15:0]           pos_y,
  input  logic [15:0]                  label_id,
  input  logic [9:0]                   match_distance,
  input  logic [9:0]                   anchor_offset,
  input  logic [9:0]                   screen_margin,
  input  logic signed [15:0]           screen_top,
  input  logic signed [15:0]           screen_bottom,
  output logic                         out_strobe,
  output logic                         out_cluster_valid,
  output logic signed [15:0]           out_x,
  output logic signed [15:0]           out_y,
  output logic [15:0]                  out_member_count,
  output logic [1:0]                   out_shown_labels,
  output logic [15:0]                  out_label_first,
  output logic [15:0]                  out_label_second,
  output logic [15:0]                  out_label_third,
  output logic [15:0]                  out_overflow_count,
  output logic                         out_last
);
  import plc_pkg::*;
  localparam int IW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int TW = $clog2(MAX_CLUSTERS + 1);
  localparam int NL = (LABEL_SLOTS < 3) ? LABEL_SLOTS : 3;

  logic signed [15:0] x_r, y_r;
  logic [15:0] lab_r;
  logic [TW-1:0] total_r;
  logic [TW-1:0] idx_r;
  logic [IW-1:0] hit_idx_r;
  logic [15:0] hit_cnt_r;
  logic [15:0] ax_q, ay_q, cnt_q;
  logic [15:0] lq [3];

  wire [IW-1:0] idx_a = idx_r[IW-1:0];

  assign sts.at_end = (idx_r == total_r);
  assign sts.empty = (total_r == '0);
  assign sts.full = (total_r == TW'(MAX_CLUSTERS));
  assign sts.last_idx = (idx_r + TW'(1) == total_r);

  // per-axis distance compare on registered read data
  logic signed [17:0] dx, dy, adx, ady;
  always_comb begin
    dx = 18'(x_r) - 18'(signed'(ax_q));
    dy = 18'(y_r) - 18'(signed'(ay_q));
    adx = dx[17] ? -dx : dx;
    ady = dy[17] ? -dy : dy;
  end
  assign sts.hit = (adx <= 18'(match_distance)) && (ady <= 18'(match_distance));

  // write ports
  logic we_a, we_c, we_l;
  logic [IW-1:0] wa;
  logic [15:0] wcnt;
  logic [15:0] cur_cnt;
  always_comb begin
    we_a = cmd.wr_new;
    we_c = cmd.wr_new | cmd.wr_hit;
    wa = cmd.wr_new ? total_r[IW-1:0] : hit_idx_r;
    cur_cnt = cmd.wr_new ? 16'd0 : hit_cnt_r;
    wcnt = (cur_cnt == 16'hFFFF) ? cur_cnt : cur_cnt + 16'd1;
    we_l = we_c && (cur_cnt < 16'(LABEL_SLOTS));
  end

  plc_ram #(.WIDTH(16), .DEPTH(MAX_CLUSTERS)) u_ax (
    .clk, .we(we_a), .waddr(wa), .wdata(x_r), .raddr(idx_a), .rdata(ax_q));
  plc_ram #(.WIDTH(16), .DEPTH(MAX_CLUSTERS)) u_ay (
    .clk, .we(we_a), .waddr(wa), .wdata(y_r), .raddr(idx_a), .rdata(ay_q));
  plc_ram #(.WIDTH(16), .DEPTH(MAX_CLUSTERS)) u_cnt (
    .clk, .we(we_c), .waddr(wa), .wdata(wcnt), .raddr(idx_a), .rdata(cnt_q));

  // label store banked by line so the flush reads all shown labels at once
  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_lab
      if (g < NL) begin : g_bank
        logic [15:0] rd;
        plc_ram #(.WIDTH(16), .DEPTH(MAX_CLUSTERS)) u_lab (
          .clk, .we(we_l && (cur_cnt == 16'(g))), .waddr(wa), .wdata(lab_r),
          .raddr(idx_a), .rdata(rd));
        assign lq[g] = rd;
      end else begin : g_none
        assign lq[g] = 16'd0;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      idx_r <= '0;
    end else begin
      if (cmd.idx_clr) idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + TW'(1);
      if (cmd.clr) total_r <= '0;
      else if (cmd.wr_new) total_r <= total_r + TW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= pos_x;
      y_r <= pos_y;
      lab_r <= label_id;
    end
    if (cmd.chk) begin
      hit_idx_r <= idx_a;
      hit_cnt_r <= cnt_q;
    end
  end

  // flush formatting
  logic signed [18:0] yo_dn, yo_up, lim_t, lim_b, ysel;
  logic [15:0] stored;
  always_comb begin
    yo_dn = 19'(signed'(ay_q)) - 19'(anchor_offset);
    yo_up = 19'(signed'(ay_q)) + 19'(anchor_offset);
    lim_t = 19'(screen_top) + 19'(screen_margin);
    lim_b = 19'(screen_bottom) - 19'(screen_margin);
    if (yo_dn > lim_t) ysel = yo_dn;
    else if (yo_up < lim_b) ysel = yo_up;
    else ysel = 19'(signed'(ay_q));
    stored = (cnt_q < 16'(LABEL_SLOTS)) ? cnt_q : 16'(LABEL_SLOTS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else out_strobe <= cmd.emit | cmd.emit_empty;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_empty) begin
      out_cluster_valid <= 1'b0;
      out_x <= '0; out_y <= '0; out_member_count <= '0;
      out_shown_labels <= '0; out_label_first <= '0; out_label_second <= '0;
      out_label_third <= '0; out_overflow_count <= '0; out_last <= 1'b1;
    end else if (cmd.emit) begin
      out_cluster_valid <= 1'b1;
      out_x <= ax_q;
      if (ysel > 19'sd32767) out_y <= 16'sh7FFF;
      else if (ysel < -19'sd32768) out_y <= 16'sh8000;
      else out_y <= ysel[15:0];
      out_member_count <= cnt_q;
      out_shown_labels <= (cnt_q > 16'(LABEL_SLOTS)) ? 2'(LABEL_SLOTS - 1)
                                                   : cnt_q[1:0];
      out_label_first <= (stored > 16'd0) ? lq[0] : 16'd0;
      out_label_second <= (stored > 16'd1) ? lq[1] : 16'd0;
      out_label_third <= (stored > 16'd2) ? lq[2] : 16'd0;
      out_overflow_count <= (cnt_q > 16'(LABEL_SLOTS)) ?
                            cnt_q - 16'(LABEL_SLOTS - 1) : 16'd0;
      out_last <= sts.last_idx;
    end
  end
endmodule

[hdl/proximity_label_clusterer_top.sv]
// ----------------------------------------------------------------------------
// proximity_label_clusterer_top
// Greedy leader clustering of screen points with per-axis match distance.
// ----------------------------------------------------------------------------
// channel | ports                      | handshake
// input   | in_req_type .. in_label_id | start & !busy
// result  | out_*                      | out_strobe, one cycle
// config  | cfg_we, cfg_idx, cfg_data  | cfg_we
//
// Add: each stored anchor is read (S_RD) and compared (S_CHK) in order; a match is
//   updated (S_UPD), else a new cluster is appended if not full. busy blocks new requests.
// Flush: each cluster is read (S_FRD) and emitted (S_FOUT) in turn; an empty table gives one empty result.
// Both walks go through the single read port of the anchor/count RAMs in order.
// Synchronous reset empties the table at once; no clearing pass.
// Results cannot be stalled.
`timescale 1ns / 1ps
module proximity_label_clusterer_top #(
  parameter int MAX_CLUSTERS = plc_pkg::MAX_CLUSTERS_DEF,
  parameter int LABEL_SLOTS  = plc_pkg::LABEL_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_req_type,
  input  logic signed [15:0]             in_pos_x,
  input  logic signed [15:0]             in_pos_y,
  input  logic [15:0]                    in_label_id,
  output logic                           out_strobe,
  output logic                           out_cluster_valid,
  output logic signed [15:0]             out_x,
  output logic signed [15:0]             out_y,
  output logic [15:0]                    out_member_count,
  output logic [1:0]                     out_shown_labels,
  output logic [15:0]                    out_label_first,
  output logic [15:0]                    out_label_second,
  output logic [15:0]                    out_label_third,
  output logic [15:0]                    out_overflow_count,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [plc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [plc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import plc_pkg::*;
  logic [9:0] match_r, ofs_r, margin_r;
  logic signed [15:0] top_r, bottom_r;
  plc_cmd_t cmd;
  plc_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 10'd20;
      ofs_r <= 10'd18;
      margin_r <= 10'd12;
      top_r <= 16'sd0;
      bottom_r <= 16'sd480;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MATCH_DIST: match_r <= cfg_data[9:0];
        REG_ANCHOR_OFS: ofs_r <= cfg_data[9:0];
        REG_MARGIN:     margin_r <= cfg_data[9:0];
        REG_TOP:        top_r <= cfg_data;
        REG_BOTTOM:     bottom_r <= cfg_data;
        default: ;
      endcase
    end
  end

  plc_ctrl u_ctrl (
    .clk, .rst_n, .start(start & ~busy), .req_type(in_req_type),
    .sts, .cmd, .busy);

  plc_dp #(.MAX_CLUSTERS(MAX_CLUSTERS), .LABEL_SLOTS(LABEL_SLOTS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .pos_x(in_pos_x), .pos_y(in_pos_y), .label_id(in_label_id),
    .match_distance(match_r), .anchor_offset(ofs_r), .screen_margin(margin_r),
    .screen_top(top_r), .screen_bottom(bottom_r),
    .out_strobe, .out_cluster_valid, .out_x, .out_y, .out_member_count,
    .out_shown_labels, .out_label_first, .out_label_second, .out_label_third,
    .out_overflow_count, .out_last);
endmodule

[hdl/plc_checker.sv]
// ----------------------------------------------------------------------------
// plc_checker
// Port-level checks on the clusterer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "proximity_label_clusterer_top_assert.svh"
module plc_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_req_type,
  input logic out_strobe,
  input logic out_cluster_valid,
  input logic [15:0] out_member_count,
  input logic [1:0] out_shown_labels,
  input logic [15:0] out_overflow_count,
  input logic out_last
);
  `PLC_ASSERT_NXT(a_add_no_out, start && !busy && !in_req_type, !out_strobe)
  `PLC_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `PLC_ASSERT_IMP(a_empty_last, out_strobe && !out_cluster_valid, out_last)
  `PLC_ASSERT_IMP(a_valid_cnt, out_strobe && out_cluster_valid,
                  out_member_count != 16'd0)
  `PLC_ASSERT_IMP(a_overflow, out_strobe && out_overflow_count != 16'd0,
                  out_shown_labels == 2'd2)
endmodule

bind proximity_label_clusterer_top plc_checker u_plc_checker (
  .clk, .rst_n, .start, .busy, .in_req_type, .out_strobe, .out_cluster_valid,
  .out_member_count, .out_shown_labels, .out_overflow_count, .out_last);
